[hdl/hrtc_pkg.sv]
package hrtc_pkg;

  // Field and register widths
  localparam int SAMPLE_W = 12;
  localparam int RATE_W   = 16;
  localparam int INDEX_W  = 2;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [INDEX_W-1:0] REG_NUMERATOR = 2'd1;

  // Register values after reset
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2400;
  localparam logic [RATE_W-1:0]   NUMERATOR_RESET = 16'd15000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // take the sample of an accepted request
    logic eval;        // advance the interval count and test for a beat
    logic rate_step;   // one quotient bit of numerator / interval
    logic push;        // shift the rate into the window
    logic mean_store;  // keep the mean taken from the window sum
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic beat_hit;    // the held sample registers a beat
    logic div_last;    // the divider performs its last step this cycle
    logic out_free;    // the output register can take a result this cycle
  } sts_t;

endpackage

[hdl/heart_rate_from_threshold_crossings.sv]
// Heart-rate estimator on a stream of 12-bit ECG samples. Each accepted sample
// gives exactly one result: a beat flag, the instantaneous rate
// (rate_numerator / samples since the previous beat, zero when there is no
// beat) and the mean of the last WINDOW_DEPTH rates, where slots not yet
// filled since reset count as zero. A sample without a beat goes from
// evaluation straight to the output register. A beat goes on through the
// restoring divider that produces one quotient bit of the rate per cycle,
// the window push and the mean store, where the mean comes from the window
// sum by a reciprocal multiplication. The next sample is accepted only once
// the previous result is loaded into the output register, and is accepted
// while a result waits at the output. Write the configuration registers
// only while the block is idle.
module heart_rate_from_threshold_crossings
  import hrtc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]  cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // [11:0] sample
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // [15:0] instant_rate, [31:16] mean_rate
  output logic               out_tuser   // [0] beat
);

  cmd_t              cmd;
  sts_t              sts;
  logic [RATE_W-1:0] out_rate;
  logic [RATE_W-1:0] out_mean;

  // Sequencer
  hrtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Detector, divider, window and output register
  hrtc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_beat   (out_tuser),
    .out_rate   (out_rate),
    .out_mean   (out_mean)
  );

  assign out_tdata = {out_mean, out_rate};

endmodule

[hdl/hrtc_ctrl.sv]
module hrtc_ctrl
  import hrtc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_RATE  = 6'b000100,
    S_PUSH  = 6'b001000,
    S_STORE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.beat_hit ? S_RATE : S_DONE;
      end
      S_RATE: begin
        cmd.rate_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.mean_store = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/hrtc_dp.sv]
module hrtc_dp
  import hrtc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [RATE_W-1:0]   cfg_wdata,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_beat,
  output logic [RATE_W-1:0]   out_rate,
  output logic [RATE_W-1:0]   out_mean
);

  // Sum width holds WINDOW_DEPTH full-scale rates
  localparam int SW = RATE_W + $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(SW + 1);
  localparam logic [CW-1:0]     RATE_STEPS    = CW'(RATE_W);
  localparam logic [SW-1:0]     SUM_MAX       = SW'(WINDOW_DEPTH * 65535);

  // Mean by reciprocal multiplication: exact for every SW-bit sum because
  // 2^MEAN_SHIFT is at least WINDOW_DEPTH times the largest sum.
  localparam int     MEAN_SHIFT  = SW + $clog2(WINDOW_DEPTH);
  localparam int     MW          = SW + 1;
  localparam int     PW          = 2 * SW + 1;
  localparam longint MEAN_MULT_L =
    ((longint'(1) << MEAN_SHIFT) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);
  localparam logic [MW-1:0] MEAN_MULT = MW'(MEAN_MULT_L);

  logic [SAMPLE_W-1:0] beat_threshold;
  logic [RATE_W-1:0]   rate_numerator;

  logic [SAMPLE_W-1:0] sample;
  logic                armed;
  logic [RATE_W-1:0]   interval_count;
  logic [RATE_W-1:0]   count_inc;
  logic                beat;
  logic [RATE_W-1:0]   rate;
  logic [RATE_W-1:0]   last_mean;

  logic [RATE_W-1:0]   rate_window [WINDOW_DEPTH];
  logic [SW-1:0]       window_sum;
  logic [SW-1:0]       sum_next;
  logic [PW-1:0]       mean_product;

  logic [SW-1:0]       dividend;
  logic [RATE_W-1:0]   remainder;
  logic [RATE_W-1:0]   divisor;
  logic [CW-1:0]       div_count;
  logic [RATE_W:0]     rem_shift;
  logic                rem_fits;
  logic                div_step;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_threshold <= THRESHOLD_RESET;
      rate_numerator <= NUMERATOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: beat_threshold <= cfg_wdata[SAMPLE_W-1:0];
        REG_NUMERATOR: rate_numerator <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Beat test on the held sample with the count already advanced
  assign count_inc    = (interval_count == '1) ? interval_count : interval_count + 1'b1;
  assign sts.beat_hit = armed && (sample > beat_threshold);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= in_sample;
    end
  end

  // Detector state and interval count
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b1;
      interval_count <= '0;
    end else if (cmd.eval) begin
      if (sts.beat_hit) begin
        armed          <= 1'b0;
        interval_count <= '0;
      end else begin
        interval_count <= count_inc;
        if (!armed && (sample <= beat_threshold)) begin
          armed <= 1'b1;
        end
      end
    end
  end

  // Restoring divider for the rate, one quotient bit per cycle
  assign div_step     = cmd.rate_step;
  assign rem_shift    = {remainder, dividend[SW-1]};
  assign rem_fits     = rem_shift >= {1'b0, divisor};
  assign sts.div_last = div_step && (div_count == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.eval && sts.beat_hit) begin
      dividend  <= {rate_numerator, {(SW - RATE_W){1'b0}}};
      remainder <= '0;
      divisor   <= count_inc;
      div_count <= RATE_STEPS;
    end else if (div_step) begin
      if (rem_fits) begin
        remainder <= RATE_W'(rem_shift - {1'b0, divisor});
      end else begin
        remainder <= rem_shift[RATE_W-1:0];
      end
      dividend  <= {dividend[SW-2:0], rem_fits};
      div_count <= div_count - 1'b1;
    end
  end

  // Rate window as a shift line with a running sum
  assign sum_next     = window_sum - SW'(rate_window[0]) + SW'(dividend[RATE_W-1:0]);
  assign mean_product = PW'(window_sum) * PW'(MEAN_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        rate_window[i] <= '0;
      end
      window_sum <= '0;
      last_mean  <= '0;
    end else begin
      if (cmd.push) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          rate_window[i] <= rate_window[i+1];
        end
        rate_window[WINDOW_DEPTH-1] <= dividend[RATE_W-1:0];
        window_sum                  <= sum_next;
      end
      if (cmd.mean_store) begin
        last_mean <= mean_product[MEAN_SHIFT +: RATE_W];
      end
    end
  end

  // Per-sample beat flag and rate
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      beat <= sts.beat_hit;
      if (!sts.beat_hit) begin
        rate <= '0;
      end
    end else if (cmd.push) begin
      rate <= dividend[RATE_W-1:0];
    end
  end

  // Output register
  assign sts.out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_beat <= beat;
      out_rate <= rate;
      out_mean <= last_mean;
    end
  end

`ifndef SYNTHESIS
  // A result without a beat carries a zero rate.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && !beat |=> out_rate == '0)
    else $error("rate nonzero on a result without a beat");

  // The detector disarms only while a sample is being evaluated.
  assert property (@(posedge clk) disable iff (rst)
    $fell(armed) |-> $past(cmd.eval))
    else $error("detector disarmed outside evaluation");

  // A beat restarts the interval count.
  assert property (@(posedge clk) disable iff (rst)
    cmd.eval && sts.beat_hit |=> interval_count == '0 && !armed)
    else $error("interval count not restarted at a beat");

  // The running sum never exceeds a window of full-scale rates.
  assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_MAX)
    else $error("window sum out of range");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import hrtc_pkg::*;

  localparam int WINDOW = 10;
  // A generous hang limit, well above a beat and the longest random stall.
  localparam int HANG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES = 8;
  localparam int PHASE_SAMPLES = 160;

  // Register indexes that the block does not decode; writes to them are ignored.
  localparam logic [INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              beat;
    logic [RATE_W-1:0] inst;
    logic [RATE_W-1:0] mean;
  } reading_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    int                  reps;
    bit                  typed;
    reading_t            want;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [INDEX_W-1:0] cfg_index;
  logic [RATE_W-1:0]  cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [15:0]        in_tdata;   // [11:0] sample
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;  // [15:0] instant_rate, [31:16] mean_rate
  logic               out_tuser;  // [0] beat

  heart_rate_from_threshold_crossings #(
    .WINDOW_DEPTH(WINDOW)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Rate estimator state as the block should hold it.
  logic [SAMPLE_W-1:0] thr_q;
  logic [RATE_W-1:0]   num_q;
  logic                armed_q;
  logic [RATE_W-1:0]   interval_q;
  logic [RATE_W-1:0]   rate_win [WINDOW];
  logic [31:0]         win_sum;
  logic [RATE_W-1:0]   mean_q;

  reading_t pending_readings [$];
  int       errors;
  int       idle_run;
  bit       steady;

  // Directed samples at the default threshold of 2400 and numerator of 15000.
  stim_row_t steps [26] = '{
    '{12'd4095, 1, 1'b1, '{1'b1, 16'd15000, 16'd1500}},  // first sample beats
    '{12'd0,    1, 1'b1, '{1'b0, 16'd0,     16'd1500}},  // re-arm
    '{12'd4095, 1, 1'b1, '{1'b1, 16'd7500,  16'd2250}},
    '{12'd4095, 1, 1'b1, '{1'b0, 16'd0,     16'd2250}},  // still disarmed
    '{12'd2400, 1, 1'b1, '{1'b0, 16'd0,     16'd2250}},  // equal re-arms
    '{12'd2401, 1, 1'b1, '{1'b1, 16'd5000,  16'd2750}},  // just above beats
    '{12'h555,  1, 1'b0, '0},
    '{12'hAAA,  1, 1'b0, '0},
    '{12'h555,  8, 1'b0, '0},
    '{12'hAAA,  1, 1'b0, '0},
    '{12'd0,    3, 1'b0, '0},
    '{12'd4095, 1, 1'b0, '0},
    '{12'd1,    5, 1'b0, '0},
    '{12'd3000, 1, 1'b0, '0},
    '{12'd2399, 2, 1'b0, '0},
    '{12'd2401, 1, 1'b0, '0},
    '{12'd100, 12, 1'b0, '0},
    '{12'd4000, 1, 1'b0, '0},
    '{12'd0,    1, 1'b0, '0},
    '{12'd4095, 1, 1'b0, '0},   // window now full
    '{12'd500, 20, 1'b0, '0},
    '{12'd2500, 1, 1'b0, '0},   // oldest rate drops out
    '{12'd0,  150, 1'b0, '0},   // long interval, low rate
    '{12'd4095, 1, 1'b0, '0},
    '{12'd0,    1, 1'b0, '0},
    '{12'd4095, 1, 1'b0, '0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Expected reading for one accepted sample; advances the predicted state.
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    reading_t          r;
    logic [RATE_W-1:0] oldest;
    r = '0;
    if (interval_q != 16'hFFFF) begin
      interval_q = interval_q + 16'd1;
    end
    if (armed_q && s > thr_q) begin
      r.inst = num_q / interval_q;
      oldest = rate_win[0];
      for (int k = 0; k < WINDOW - 1; k++) begin
        rate_win[k] = rate_win[k+1];
      end
      rate_win[WINDOW-1] = r.inst;
      win_sum = win_sum - oldest + r.inst;
      mean_q = RATE_W'(win_sum / 32'(WINDOW));
      r.beat = 1'b1;
      armed_q = 1'b0;
      interval_q = '0;
    end else if (!armed_q && s <= thr_q) begin
      armed_q = 1'b1;
    end
    r.mean = mean_q;
    return r;
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 11) begin
      return 0;
    end else if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one sample after a random gap and hold it until it is accepted.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input reading_t want);
    int       gap;
    reading_t got;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, s};
    do @(posedge clk); while (!in_tready);
    got = predict_reading(s);
    pending_readings.push_back(typed ? want : got);
  endtask

  // Stop sending and wait for every outstanding reading.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_q = val[SAMPLE_W-1:0];
      REG_NUMERATOR: num_q = val;
      default: ;
    endcase
  endtask

  // Sink side: random backpressure on the result stream.
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        hold = idle_cycles();
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker and hang watchdog.
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      idle_run <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_readings.size() == 0) begin
          $error("reading with no request outstanding: beat %0d rate %0d mean %0d",
                 out_tuser, out_tdata[15:0], out_tdata[31:16]);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          if (out_tuser !== want.beat) begin
            $error("beat: expected %0d, got %0d", want.beat, out_tuser);
            errors++;
          end
          if (out_tdata[15:0] !== want.inst) begin
            $error("instant_rate: expected %0d, got %0d", want.inst, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[31:16] !== want.mean) begin
            $error("mean_rate: expected %0d, got %0d", want.mean, out_tdata[31:16]);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= HANG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Main sequence: directed table, then random phases under several settings.
  initial begin
    logic [RATE_W-1:0]   thr_w;
    logic [RATE_W-1:0]   num_w;
    logic [SAMPLE_W-1:0] s;
    int                  n;
    int                  quiet;
    int                  peaks;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    steady = 1'b0;

    thr_q = THRESHOLD_RESET;
    num_q = NUMERATOR_RESET;
    armed_q = 1'b1;
    interval_q = '0;
    for (int k = 0; k < WINDOW; k++) begin
      rate_win[k] = '0;
    end
    win_sum = '0;
    mean_q = '0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      steady = (steps[i].reps > 100);
      repeat (steps[i].reps) begin
        send_sample(steps[i].sample, steps[i].typed, steps[i].want);
      end
    end
    steady = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // The sender holds off until the block has caught up before each setting.
      drain();
      case (ph)
        0: begin thr_w = 16'd2400;  num_w = 16'd15000; end
        1: begin thr_w = 16'd0;     num_w = 16'd1;     end
        2: begin thr_w = 16'd4095;  num_w = 16'hFFFF;  end
        3: begin thr_w = 16'hF123;  num_w = 16'hFFFF;  end  // upper bits dropped
        4: begin thr_w = 16'd1000;  num_w = 16'd0;     end  // zero numerator
        5: begin thr_w = 16'd3000;  num_w = 16'd30000; end
        default: begin
          thr_w = 16'($urandom_range(0, 4095));
          num_w = 16'($urandom_range(1, 65535));
        end
      endcase
      write_reg(REG_THRESHOLD, thr_w);
      write_reg(REG_NUMERATOR, num_w);
      if (ph == 5) begin
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
      end
      steady = (ph == 6) || ($urandom_range(0, 3) == 0);

      // Mostly quiet stretches ending in a short peak, with some raw noise.
      n = 0;
      while (n < PHASE_SAMPLES) begin
        if (thr_q != 12'hFFF && $urandom_range(0, 4) != 0) begin
          quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 300)
                                              : $urandom_range(1, 25);
          peaks = $urandom_range(1, 3);
          repeat (quiet) begin
            s = SAMPLE_W'($urandom_range(0, int'(thr_q)));
            send_sample(s, 1'b0, '0);
            n++;
          end
          repeat (peaks) begin
            s = SAMPLE_W'($urandom_range(int'(thr_q) + 1, 4095));
            send_sample(s, 1'b0, '0);
            n++;
          end
        end else begin
          s = SAMPLE_W'($urandom_range(0, 4095));
          send_sample(s, 1'b0, '0);
          n++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
